// File: design/sorted_table_engine_unit_defines.svh
// ---------------------------------------------------------------------------
// Sorted table engine assertion macros
// Concurrent property wrappers; they compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_ENGINE_UNIT_DEFINES_SVH
`define SORTED_TABLE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sorted table engine: same-cycle check failed");
// next-cycle implication
`define STE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sorted table engine: next-cycle check failed");
`else
`define STE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ste_pkg.sv
// ---------------------------------------------------------------------------
// Sorted table engine package
// Shared constants, operation and status codes, controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int POS_W = 6;
	localparam int ST_W  = 3;
	localparam int IDX_W = 6;
	localparam int CAP_W = 7;
	localparam int EC_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 3;

	// operations
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd3;
	localparam logic [OP_W-1:0] OP_APPEND    = 3'd4;
	localparam logic [OP_W-1:0] OP_REPLACE   = 3'd5;

	// result status
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
	localparam logic [ST_W-1:0] ST_RANGE   = 3'd2;
	localparam logic [ST_W-1:0] ST_ORDER   = 3'd3;
	localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

	// table read address select
	localparam logic [2:0] RD_PTR    = 3'd0;
	localparam logic [2:0] RD_PTR_M1 = 3'd1;
	localparam logic [2:0] RD_PTR_P1 = 3'd2;
	localparam logic [2:0] RD_LEFT   = 3'd3;
	localparam logic [2:0] RD_RIGHT  = 3'd4;

	typedef struct packed {
		logic            load;
		logic            ptr_count;
		logic            ptr_zero;
		logic            ptr_inc;
		logic            ptr_dec;
		logic            rd_en;
		logic [2:0]      rd_sel;
		logic            wr_en;
		logic            wr_rdata;
		logic            wr_at_pos;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            set_status;
		logic [ST_W-1:0] status;
		logic            set_idx;
		logic            finish;
	} ste_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             full;
		logic             pos_lt_count;
		logic             left_exists;
		logic             right_exists;
		logic             ptr_zero;
		logic             ptr_at_pos;
		logic             ptr_at_count;
		logic             ptr_p1_ge_count;
		logic             rd_lt_v;
		logic             rd_gt_v;
		logic             rd_eq_v;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} ste_stat_t;

endpackage

`default_nettype wire

// File: design/ste_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ste_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/ste_ctrl.sv
// ---------------------------------------------------------------------------
// Sorted table engine controller
// Sequences checks, scans and shifts of one operation at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module ste_ctrl import ste_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  ste_stat_t  stat,
	output ste_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_L_RD   = 4'd2;
	localparam logic [3:0] S_L_CMP  = 4'd3;
	localparam logic [3:0] S_R_RD   = 4'd4;
	localparam logic [3:0] S_R_CMP  = 4'd5;
	localparam logic [3:0] S_COMMIT = 4'd6;
	localparam logic [3:0] S_UP_CHK = 4'd7;
	localparam logic [3:0] S_UP_CMP = 4'd8;
	localparam logic [3:0] S_SR_CHK = 4'd9;
	localparam logic [3:0] S_SR_CMP = 4'd10;
	localparam logic [3:0] S_DN_CHK = 4'd11;
	localparam logic [3:0] S_DN_WR  = 4'd12;
	localparam logic [3:0] S_FIN    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       up_stop;

	// place the value without further shifting
	assign up_stop = stat.ptr_zero || (stat.op == OP_APPEND) ||
		((stat.op == OP_INSERT_AT) && stat.ptr_at_pos);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.ptr_count = 1'b1;
							state_d       = S_UP_CHK;
						end
					end
					OP_SEARCH, OP_REMOVE: begin
						cmd.ptr_zero = 1'b1;
						state_d      = S_SR_CHK;
					end
					OP_INSERT_AT: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else if (!stat.pos_lt_count) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							state_d = S_L_RD;
						end
					end
					OP_APPEND: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							state_d = S_L_RD;
						end
					end
					OP_REPLACE: begin
						if (!stat.pos_lt_count) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							state_d = S_L_RD;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_L_RD: begin
				if (stat.left_exists) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
					state_d    = S_L_CMP;
				end else begin
					state_d = S_R_RD;
				end
			end
			S_L_CMP: begin
				if (stat.rd_gt_v) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_ORDER;
					state_d        = S_FIN;
				end else begin
					state_d = S_R_RD;
				end
			end
			S_R_RD: begin
				if (stat.right_exists) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
					state_d    = S_R_CMP;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_R_CMP: begin
				if (stat.rd_lt_v) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_ORDER;
					state_d        = S_FIN;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.op == OP_REPLACE) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_at_pos = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.ptr_count = 1'b1;
					state_d       = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (up_stop) begin
					cmd.wr_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_M1;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if ((stat.op == OP_INSERT) && stat.rd_lt_v) begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.wr_rdata = 1'b1;
					cmd.ptr_dec  = 1'b1;
					state_d      = S_UP_CHK;
				end
			end
			S_SR_CHK: begin
				if (stat.ptr_at_count) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_MISSING;
					state_d        = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR;
					state_d    = S_SR_CMP;
				end
			end
			S_SR_CMP: begin
				if (stat.rd_eq_v) begin
					cmd.set_idx = 1'b1;
					state_d     = (stat.op == OP_SEARCH) ? S_FIN : S_DN_CHK;
				end else if (stat.rd_gt_v) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_MISSING;
					state_d        = S_FIN;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SR_CHK;
				end
			end
			S_DN_CHK: begin
				if (stat.ptr_p1_ge_count) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_P1;
					state_d    = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_rdata = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: design/ste_dp.sv
// ---------------------------------------------------------------------------
// Sorted table engine datapath
// Table memory, count, capacity, scan pointer, comparators, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ste_dp import ste_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [CAP_W-1:0]       cfg_capacity,
	input  wire  [OP_W-1:0]        in_operation,
	input  wire  [VAL_W-1:0]       in_value,
	input  wire  [POS_W-1:0]       in_position,
	input  ste_cmd_t               cmd,
	output ste_stat_t              stat,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [ST_W-1:0]        out_status,
	output logic [IDX_W-1:0]       out_found_index,
	output logic [EC_W-1:0]        out_entry_count
);

	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [ST_W-1:0]         status_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    out_valid_q;
	logic [ST_W-1:0]         out_status_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [EC_W-1:0]         out_count_q;

	logic [CAP_W-1:0]        limit;
	logic [CNT_W-1:0]        pos_ext;
	logic [CNT_W-1:0]        left_addr;
	logic [CNT_W-1:0]        right_addr;
	logic [CNT_W-1:0]        rd_addr;
	logic [CNT_W-1:0]        wr_addr;
	logic [CNT_W-1:0]        ptr_p1;
	logic [VAL_W-1:0]        wdata;
	logic [VAL_W-1:0]        rdata;
	logic signed [VAL_W-1:0] rd_s;

	assign limit   = (cap_q < CAP_W'(DEPTH)) ? cap_q : CAP_W'(DEPTH);
	assign pos_ext = CNT_W'(pos_q);
	assign ptr_p1  = ptr_q + CNT_W'(1);
	assign rd_s    = rdata;

	// neighbors: append looks at the last entry, the others around position
	assign left_addr  = (op_q == OP_APPEND) ? (count_q - CNT_W'(1)) : (pos_ext - CNT_W'(1));
	assign right_addr = (op_q == OP_REPLACE) ? (pos_ext + CNT_W'(1)) : pos_ext;

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR:    rd_addr = ptr_q;
			RD_PTR_M1: rd_addr = ptr_q - CNT_W'(1);
			RD_PTR_P1: rd_addr = ptr_p1;
			RD_LEFT:   rd_addr = left_addr;
			RD_RIGHT:  rd_addr = right_addr;
			default:   rd_addr = ptr_q;
		endcase
	end

	assign wr_addr = cmd.wr_at_pos ? pos_ext : ptr_q;
	assign wdata   = cmd.wr_rdata ? rdata : val_q;

	ste_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wr_addr[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (rd_addr[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		stat                 = '0;
		stat.op              = op_q;
		stat.full            = (count_q >= CNT_W'(limit));
		stat.pos_lt_count    = (pos_ext < count_q);
		stat.left_exists     = (op_q == OP_APPEND) ? (count_q != '0) : (pos_q != '0);
		stat.right_exists    = (op_q == OP_REPLACE) ? (right_addr < count_q) :
			(op_q == OP_INSERT_AT);
		stat.ptr_zero        = (ptr_q == '0);
		stat.ptr_at_pos      = (ptr_q == pos_ext);
		stat.ptr_at_count    = (ptr_q == count_q);
		stat.ptr_p1_ge_count = (ptr_p1 >= count_q);
		stat.rd_lt_v         = (rd_s < val_q);
		stat.rd_gt_v         = (rd_s > val_q);
		stat.rd_eq_v         = (rd_s == val_q);
		stat.out_free        = !out_valid_q || out_ready;
		stat.count           = count_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_capacity;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-operation payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_operation;
			val_q    <= in_value;
			pos_q    <= in_position;
			status_q <= ST_OK;
			idx_q    <= '0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.set_idx) begin
			idx_q <= ptr_q[IDX_W-1:0];
		end
		if (cmd.ptr_count) begin
			ptr_q <= count_q;
		end else if (cmd.ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_p1;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - CNT_W'(1);
		end
		if (cmd.finish) begin
			out_status_q <= status_q;
			out_idx_q    <= idx_q;
			out_count_q  <= EC_W'(count_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found_index = out_idx_q;
	assign out_entry_count = out_count_q;

endmodule

`default_nettype wire

// File: design/sorted_table_engine_unit.sv
// ---------------------------------------------------------------------------
// Sorted table engine
// Ascending table of signed 32-bit values with insert, search, remove, positional insert, append and replace.
// ---------------------------------------------------------------------------
// The block keeps up to 64 signed values in ascending order in a single
// one-write, one-read table memory and runs one operation per input
// transaction: sorted insert, search, remove, insert at a position, append
// and replace at a position, each returning exactly one result transaction
// with a status, the found index and the entry count after the operation.
// Operations run one at a time; a new transaction is taken as soon as the
// previous one has left its result in the output register, even if that
// result has not been taken yet. The table memory gives one registered
// read per cycle, so every entry that is scanned (search, remove up to the
// match) or moved (entries above the insert point, entries above the
// removed one) takes a read, then a compare or a write. The capacity
// register may be written at any time the block is idle; capacity is
// clamped to the table depth and a capacity of zero reports full on every
// insertion. The table contents need no clearing after reset: only entries
// below the current count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_engine_unit_defines.svh"

module sorted_table_engine_unit import ste_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	// capacity register write
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CAP_W-1:0]       cfg_data,
	// request stream
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value, [37:32] position
	input  wire  [IN_TUSER_W-1:0]  s_axis_tuser,  // [2:0] operation
	// result stream
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [5:0] found_index, [12:6] entry_count
	output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [2:0] status
);

	ste_cmd_t         ctrl_cmd;
	ste_stat_t        dp_stat;
	logic [ST_W-1:0]  res_status;
	logic [IDX_W-1:0] res_index;
	logic [EC_W-1:0]  res_count;

	// the register is a plain flop; a write never has to wait
	assign cfg_ready = 1'b1;

	// sequence one operation at a time
	ste_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	// table, counters and the result register
	ste_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_capacity    (cfg_data),
		.in_operation    (s_axis_tuser[OP_W-1:0]),
		.in_value        (s_axis_tdata[VAL_W-1:0]),
		.in_position     (s_axis_tdata[VAL_W +: POS_W]),
		.cmd             (ctrl_cmd),
		.stat            (dp_stat),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_status      (res_status),
		.out_found_index (res_index),
		.out_entry_count (res_count)
	);

	// pack the result, zero-fill to whole bytes
	assign m_axis_tdata = {{(OUT_TDATA_W - IDX_W - EC_W){1'b0}}, res_count, res_index};
	assign m_axis_tuser = res_status;

	// a taken transaction closes the request side in the cycle after it
	`STE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// failed operations report index zero
	`STE_ASSERT_IMP(a_idx_zero_on_fail, clk, arst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[IDX_W-1:0] == '0)
	// the entry count never passes the table depth
	`STE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, dp_stat.count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire
